/* rtl/ctr_pkg.sv */
`timescale 1ns / 1ps
package ctr_pkg;

  // Width of each output level; full intensity is all ones.
  localparam int LEVEL_BITS = 16;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = '1;

  // Temperature limits and the breakpoints of the fit, in kelvin.
  localparam logic [15:0] K_MIN      = 16'd1000;
  localparam logic [15:0] K_MAX      = 16'd40000;
  localparam logic [15:0] K_LOW_MAX  = 16'd6600;
  localparam logic [15:0] K_BLUE_MIN = 16'd1900;
  localparam logic [15:0] K_HIGH_OFS = 16'd6000;
  localparam logic [15:0] K_BLUE_OFS = 16'd1000;

  // Fit coefficients in Q20 and exponents in Q32, rounded to nearest.
  localparam logic [31:0] G_LOW_MUL = 32'((64'd994708025861 * 64'd1048576
                                      + 64'd5000000000) / 64'd10000000000);
  localparam logic [31:0] G_LOW_SUB = 32'((64'd1611195681661 * 64'd1048576
                                      + 64'd5000000000) / 64'd10000000000);
  localparam logic [31:0] B_LOW_MUL = 32'((64'd1385177312231 * 64'd1048576
                                      + 64'd5000000000) / 64'd10000000000);
  localparam logic [31:0] B_LOW_SUB = 32'((64'd3050447927307 * 64'd1048576
                                      + 64'd5000000000) / 64'd10000000000);
  localparam logic [28:0] R_HIGH_MUL = 29'((64'd3296987274460 * 64'd1048576
                                       + 64'd5000000000) / 64'd10000000000);
  localparam logic [31:0] R_HIGH_EXP = 32'((64'd1332047592 * 64'd4294967296
                                       + 64'd5000000000) / 64'd10000000000);
  localparam logic [28:0] G_HIGH_MUL = 29'((64'd2881221695283 * 64'd1048576
                                       + 64'd5000000000) / 64'd10000000000);
  localparam logic [31:0] G_HIGH_EXP = 32'((64'd755148492 * 64'd4294967296
                                       + 64'd5000000000) / 64'd10000000000);

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [35:0] CAP_Q28 = 36'd255 << 28;

  // Pipeline geometry.
  localparam int LOG_SQ_STEPS = 28;
  localparam int LN_LAT       = LOG_SQ_STEPS + 2;
  localparam int EXP_TERMS    = 20;
  localparam int QUO_BITS     = 29;
  localparam int NPOW_LAT     = 1 + 2 * EXP_TERMS + 1 + QUO_BITS;
  localparam int OUT_LAT      = 1 + LN_LAT + NPOW_LAT + 4;

  // Level scaling: divide by 255 through a reciprocal that is exact on LVL_W bits.
  localparam int LVL_W      = LEVEL_BITS + 8;
  localparam int LVL_S      = LVL_W + 8;
  localparam int LVL_PROD_W = 36 + LEVEL_BITS;
  localparam logic [63:0] LVL_M = ((64'd1 << LVL_S) + 64'd254) / 64'd255;

  // log2 in Q28 by normalizing and repeated squaring; used for constants only.
  function automatic logic [31:0] log2_const(input logic [15:0] x);
    logic [63:0] m;
    logic [31:0] r;
    int n;
    n = 0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) n = i;
    end
    m = 64'(x) << (31 - n);
    r = 32'(n) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [31:0] LOG2_100 = log2_const(16'd100);

endpackage

/* rtl/color_temperature_to_rgb_top.sv */
`timescale 1ns / 1ps
// Color temperature to RGB levels.
// Input: drive in_kelvin and pulse start; the word is taken at any edge where
// start is high and busy is low. busy stays low, so a word can enter every cycle.
// Kelvin is clamped to 1000..40000 inside the block.
// Output: out_valid is high for exactly one cycle with out_red_level,
// out_green_level and out_blue_level (unsigned fractions, all ones is full).
// Throughput: one word per cycle; the latency is set by the 28-stage log2
// squaring chain, the 20-term exponential series (two stages per term) and
// the 29-stage restoring divider.
// Results come out in input order. The receiver cannot stall the block and
// must take each result in the cycle it is shown.
// Reset (synchronous, active low) clears every valid bit in the pipeline;
// words in flight are dropped and no result appears until new words enter.
module color_temperature_to_rgb_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [15:0]                    in_kelvin,
  output logic                           out_valid,
  output logic [ctr_pkg::LEVEL_BITS-1:0] out_red_level,
  output logic [ctr_pkg::LEVEL_BITS-1:0] out_green_level,
  output logic [ctr_pkg::LEVEL_BITS-1:0] out_blue_level
);

  typedef struct packed {
    logic low;
    logic bzero;
  } side_t;

  logic        acc;
  logic [15:0] kc;
  logic        v0_r;
  logic [15:0] k0_r;
  side_t       s0_r;
  logic [15:0] xa;
  logic [15:0] xb;
  logic [31:0] lna;
  logic [31:0] lnb;
  logic [28:0] qr;
  logic [28:0] qg;

  logic        v1_r [0:ctr_pkg::LN_LAT-1];
  side_t       s1_r [0:ctr_pkg::LN_LAT-1];
  logic        v2_r   [0:ctr_pkg::NPOW_LAT-1];
  side_t       s2_r   [0:ctr_pkg::NPOW_LAT-1];
  logic [31:0] lna2_r [0:ctr_pkg::NPOW_LAT-1];
  logic [31:0] lnb2_r [0:ctr_pkg::NPOW_LAT-1];

  logic        v3_r;
  side_t       s3_r;
  logic [39:0] gp3_r;
  logic [39:0] bp3_r;
  logic [28:0] qr3_r;
  logic [28:0] qg3_r;
  logic [63:0] gp_nxt;
  logic [63:0] bp_nxt;

  logic        v4_r;
  logic [35:0] vr4_r;
  logic [35:0] vg4_r;
  logic [35:0] vb4_r;
  logic [35:0] vr_nxt;
  logic [35:0] vg_nxt;
  logic [35:0] vb_nxt;
  logic [39:0] gfit;
  logic [39:0] bfit;

  logic                          v5_r;
  logic [ctr_pkg::LVL_W-1:0]     wr5_r;
  logic [ctr_pkg::LVL_W-1:0]     wg5_r;
  logic [ctr_pkg::LVL_W-1:0]     wb5_r;
  logic [ctr_pkg::LVL_PROD_W-1:0] wr_nxt;
  logic [ctr_pkg::LVL_PROD_W-1:0] wg_nxt;
  logic [ctr_pkg::LVL_PROD_W-1:0] wb_nxt;

  logic                            out_valid_r;
  logic [ctr_pkg::LEVEL_BITS-1:0]  red_r;
  logic [ctr_pkg::LEVEL_BITS-1:0]  green_r;
  logic [ctr_pkg::LEVEL_BITS-1:0]  blue_r;
  logic [2*ctr_pkg::LVL_W:0]       lr_nxt;
  logic [2*ctr_pkg::LVL_W:0]       lg_nxt;
  logic [2*ctr_pkg::LVL_W:0]       lb_nxt;

  // Limit a channel value to full scale.
  function automatic logic [35:0] cap_q28(input logic [39:0] v);
    return (v > 40'(ctr_pkg::CAP_Q28)) ? ctr_pkg::CAP_Q28 : v[35:0];
  endfunction

  // Scale a capped channel value by the level range and add half for rounding.
  function automatic logic [ctr_pkg::LVL_PROD_W-1:0] lvl_scale(input logic [35:0] v);
    return ctr_pkg::LVL_PROD_W'(v) * ctr_pkg::LVL_PROD_W'(ctr_pkg::LEVEL_FULL)
           + ctr_pkg::LVL_PROD_W'(ctr_pkg::CAP_Q28 >> 1);
  endfunction

  // The pipeline never holds off the sender.
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // Clamp the temperature.
  always_comb begin
    if (in_kelvin < ctr_pkg::K_MIN) begin
      kc = ctr_pkg::K_MIN;
    end else if (in_kelvin > ctr_pkg::K_MAX) begin
      kc = ctr_pkg::K_MAX;
    end else begin
      kc = in_kelvin;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    k0_r       <= kc;
    s0_r.low   <= (kc <= ctr_pkg::K_LOW_MAX);
    s0_r.bzero <= (kc <= ctr_pkg::K_BLUE_MIN);
  end

  // Log arguments: the low range needs ln(k) and ln(k-1000), the high range ln(k-6000).
  assign xa = s0_r.low ? k0_r : k0_r - ctr_pkg::K_HIGH_OFS;
  assign xb = k0_r - ctr_pkg::K_BLUE_OFS;

  ctr_ln u_ln_a (
    .clk    (clk),
    .x      (xa),
    .ln_q28 (lna)
  );

  ctr_ln u_ln_b (
    .clk    (clk),
    .x      (xb),
    .ln_q28 (lnb)
  );

  ctr_npow u_npow_red (
    .clk    (clk),
    .ln_q28 (lna),
    .coef   (ctr_pkg::R_HIGH_MUL),
    .power  (ctr_pkg::R_HIGH_EXP),
    .quo    (qr)
  );

  ctr_npow u_npow_green (
    .clk    (clk),
    .ln_q28 (lna),
    .coef   (ctr_pkg::G_HIGH_MUL),
    .power  (ctr_pkg::G_HIGH_EXP),
    .quo    (qg)
  );

  // Valid bits alongside the log units and the power units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctr_pkg::LN_LAT; i++) v1_r[i] <= 1'b0;
      for (int i = 0; i < ctr_pkg::NPOW_LAT; i++) v2_r[i] <= 1'b0;
    end else begin
      v1_r[0] <= v0_r;
      for (int i = 1; i < ctr_pkg::LN_LAT; i++) v1_r[i] <= v1_r[i-1];
      v2_r[0] <= v1_r[ctr_pkg::LN_LAT-1];
      for (int i = 1; i < ctr_pkg::NPOW_LAT; i++) v2_r[i] <= v2_r[i-1];
    end
  end

  // Side data and logs wait for the power units.
  always_ff @(posedge clk) begin
    s1_r[0] <= s0_r;
    for (int i = 1; i < ctr_pkg::LN_LAT; i++) s1_r[i] <= s1_r[i-1];
    s2_r[0]   <= s1_r[ctr_pkg::LN_LAT-1];
    lna2_r[0] <= lna;
    lnb2_r[0] <= lnb;
    for (int i = 1; i < ctr_pkg::NPOW_LAT; i++) begin
      s2_r[i]   <= s2_r[i-1];
      lna2_r[i] <= lna2_r[i-1];
      lnb2_r[i] <= lnb2_r[i-1];
    end
  end

  // Low-range log fits: products.
  assign gp_nxt = 64'(ctr_pkg::G_LOW_MUL) * 64'(lna2_r[ctr_pkg::NPOW_LAT-1]);
  assign bp_nxt = 64'(ctr_pkg::B_LOW_MUL) * 64'(lnb2_r[ctr_pkg::NPOW_LAT-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v3_r <= v2_r[ctr_pkg::NPOW_LAT-1];
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r  <= s2_r[ctr_pkg::NPOW_LAT-1];
    gp3_r <= gp_nxt[59:20];
    bp3_r <= bp_nxt[59:20];
    qr3_r <= qr;
    qg3_r <= qg;
  end

  // Offsets, floor at zero, range select and cap.
  always_comb begin
    gfit = (gp3_r > (40'(ctr_pkg::G_LOW_SUB) << 8))
           ? gp3_r - (40'(ctr_pkg::G_LOW_SUB) << 8) : 40'd0;
    bfit = (bp3_r > (40'(ctr_pkg::B_LOW_SUB) << 8))
           ? bp3_r - (40'(ctr_pkg::B_LOW_SUB) << 8) : 40'd0;
    if (s3_r.low) begin
      vr_nxt = ctr_pkg::CAP_Q28;
      vg_nxt = cap_q28(gfit);
      vb_nxt = s3_r.bzero ? 36'd0 : cap_q28(bfit);
    end else begin
      vr_nxt = cap_q28(40'(qr3_r) << 8);
      vg_nxt = cap_q28(40'(qg3_r) << 8);
      vb_nxt = ctr_pkg::CAP_Q28;
    end
  end

  always_ff @(posedge clk) begin
    vr4_r <= vr_nxt;
    vg4_r <= vg_nxt;
    vb4_r <= vb_nxt;
  end

  // Scale to the level range.
  assign wr_nxt = lvl_scale(vr4_r);
  assign wg_nxt = lvl_scale(vg4_r);
  assign wb_nxt = lvl_scale(vb4_r);

  always_ff @(posedge clk) begin
    wr5_r <= wr_nxt[ctr_pkg::LVL_PROD_W-1:28];
    wg5_r <= wg_nxt[ctr_pkg::LVL_PROD_W-1:28];
    wb5_r <= wb_nxt[ctr_pkg::LVL_PROD_W-1:28];
  end

  // Divide by 255 with an exact reciprocal.
  assign lr_nxt = (2*ctr_pkg::LVL_W+1)'(wr5_r) * ctr_pkg::LVL_M[ctr_pkg::LVL_W:0];
  assign lg_nxt = (2*ctr_pkg::LVL_W+1)'(wg5_r) * ctr_pkg::LVL_M[ctr_pkg::LVL_W:0];
  assign lb_nxt = (2*ctr_pkg::LVL_W+1)'(wb5_r) * ctr_pkg::LVL_M[ctr_pkg::LVL_W:0];

  always_ff @(posedge clk) begin
    red_r   <= lr_nxt[ctr_pkg::LVL_S+ctr_pkg::LEVEL_BITS-1:ctr_pkg::LVL_S];
    green_r <= lg_nxt[ctr_pkg::LVL_S+ctr_pkg::LEVEL_BITS-1:ctr_pkg::LVL_S];
    blue_r  <= lb_nxt[ctr_pkg::LVL_S+ctr_pkg::LEVEL_BITS-1:ctr_pkg::LVL_S];
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

  // Every result traces back to an accepted input word.
  a_out_from_in : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, ctr_pkg::OUT_LAT))
    else $error("result without a matching input word");

  // Low temperatures give full red.
  a_low_red_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_kelvin <= ctr_pkg::K_LOW_MAX, ctr_pkg::OUT_LAT)
    |-> out_red_level == ctr_pkg::LEVEL_FULL)
    else $error("red not full for a low temperature");

  // High temperatures give full blue.
  a_high_blue_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_kelvin > ctr_pkg::K_LOW_MAX, ctr_pkg::OUT_LAT)
    |-> out_blue_level == ctr_pkg::LEVEL_FULL)
    else $error("blue not full for a high temperature");

endmodule

/* rtl/ctr_ln.sv */
`timescale 1ns / 1ps
// Pipelined natural log of x/100 in Q28, floored at zero.
module ctr_ln (
  input  logic        clk,
  input  logic [15:0] x,
  output logic [31:0] ln_q28
);

  logic [31:0] m_r [0:ctr_pkg::LOG_SQ_STEPS];
  logic [31:0] r_r [0:ctr_pkg::LOG_SQ_STEPS];
  logic        z_r [0:ctr_pkg::LOG_SQ_STEPS];
  wire  [32:0] sh_nxt [0:ctr_pkg::LOG_SQ_STEPS-1];
  logic [3:0]  msb;
  logic [31:0] m_nxt;
  logic [31:0] lx;
  logic [31:0] diff;
  logic [63:0] lnp;
  logic [31:0] ln_nxt;
  logic [31:0] ln_r;

  // Leading one position and the mantissa normalized to bit 31.
  always_comb begin
    msb = '0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) msb = 4'(i);
    end
    m_nxt = 32'(x) << (5'd31 - 5'(msb));
  end

  // One squaring per stage; each stage yields one fraction bit.
  for (genvar j = 0; j < ctr_pkg::LOG_SQ_STEPS; j++) begin : g_sq
    wire [63:0] sq;
    assign sq        = 64'(m_r[j]) * 64'(m_r[j]);
    assign sh_nxt[j] = sq[63:31];
  end

  always_ff @(posedge clk) begin
    m_r[0] <= m_nxt;
    r_r[0] <= {msb, 28'd0};
    z_r[0] <= (x == 16'd0);
    for (int j = 0; j < ctr_pkg::LOG_SQ_STEPS; j++) begin
      if (sh_nxt[j][32]) begin
        m_r[j+1] <= sh_nxt[j][32:1];
        r_r[j+1] <= r_r[j] | (32'd1 << (ctr_pkg::LOG_SQ_STEPS - 1 - j));
      end else begin
        m_r[j+1] <= sh_nxt[j][31:0];
        r_r[j+1] <= r_r[j];
      end
      z_r[j+1] <= z_r[j];
    end
  end

  // Convert to natural log relative to 100.
  always_comb begin
    lx     = z_r[ctr_pkg::LOG_SQ_STEPS] ? 32'd0 : r_r[ctr_pkg::LOG_SQ_STEPS];
    diff   = lx - ctr_pkg::LOG2_100;
    lnp    = 64'(diff) * 64'(ctr_pkg::LN2_Q32);
    ln_nxt = (lx > ctr_pkg::LOG2_100) ? lnp[63:32] : 32'd0;
  end

  always_ff @(posedge clk) begin
    ln_r <= ln_nxt;
  end

  assign ln_q28 = ln_r;

endmodule

/* rtl/ctr_npow.sv */
`timescale 1ns / 1ps
// Pipelined coef * (x/100)^-p from ln(x/100): a series for the exponential,
// then a restoring divider with one quotient bit per stage.
// The coef and power inputs are held static.
module ctr_npow (
  input  logic        clk,
  input  logic [31:0] ln_q28,
  input  logic [28:0] coef,
  input  logic [31:0] power,
  output logic [28:0] quo
);

  localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

  logic [31:0] y_r    [0:ctr_pkg::EXP_TERMS];
  logic [30:0] term_r [0:ctr_pkg::EXP_TERMS];
  logic [32:0] sum_r  [0:ctr_pkg::EXP_TERMS];
  logic [30:0] a_r    [1:ctr_pkg::EXP_TERMS];
  logic [31:0] ya_r   [1:ctr_pkg::EXP_TERMS];
  logic [32:0] suma_r [1:ctr_pkg::EXP_TERMS];
  logic [32:0] div_r  [0:ctr_pkg::QUO_BITS];
  logic [60:0] rem_r  [0:ctr_pkg::QUO_BITS];
  logic [28:0] q_r    [0:ctr_pkg::QUO_BITS];
  wire  [30:0] a_nxt    [1:ctr_pkg::EXP_TERMS];
  wire  [30:0] term_nxt [1:ctr_pkg::EXP_TERMS];
  wire  [60:0] rem_nxt  [0:ctr_pkg::QUO_BITS-1];
  wire  [28:0] q_nxt    [0:ctr_pkg::QUO_BITS-1];
  logic [63:0] yp;

  assign yp = 64'(power) * 64'(ln_q28);

  // Series terms: multiply by y, then divide by k through an exact reciprocal.
  for (genvar k = 1; k <= ctr_pkg::EXP_TERMS; k++) begin : g_term
    localparam int KS = 31 + $clog2(k);
    localparam logic [63:0] KM = ((64'd1 << KS) + 64'(k) - 64'd1) / 64'(k);
    wire [63:0] ap;
    wire [63:0] tp;
    assign ap          = 64'(term_r[k-1]) * 64'(y_r[k-1]);
    assign a_nxt[k]    = ap[60:30];
    assign tp          = 64'(a_r[k]) * KM;
    assign term_nxt[k] = 31'(tp >> KS);
  end

  // Divider steps, most significant quotient bit first.
  for (genvar j = 0; j < ctr_pkg::QUO_BITS; j++) begin : g_div
    wire [60:0] dsh;
    wire        ge;
    assign dsh        = 61'(div_r[j]) << (ctr_pkg::QUO_BITS - 1 - j);
    assign ge         = (rem_r[j] >= dsh);
    assign rem_nxt[j] = ge ? rem_r[j] - dsh : rem_r[j];
    assign q_nxt[j]   = q_r[j] | (29'(ge) << (ctr_pkg::QUO_BITS - 1 - j));
  end

  always_ff @(posedge clk) begin
    y_r[0]    <= yp[61:30];
    term_r[0] <= ONE_Q30;
    sum_r[0]  <= '0;
    for (int k = 1; k <= ctr_pkg::EXP_TERMS; k++) begin
      a_r[k]    <= a_nxt[k];
      ya_r[k]   <= y_r[k-1];
      suma_r[k] <= sum_r[k-1] + 33'(term_r[k-1]);
      term_r[k] <= term_nxt[k];
      y_r[k]    <= ya_r[k];
      sum_r[k]  <= suma_r[k];
    end
    div_r[0] <= sum_r[ctr_pkg::EXP_TERMS] + 33'(term_r[ctr_pkg::EXP_TERMS]);
    rem_r[0] <= 61'(coef) << 30;
    q_r[0]   <= '0;
    for (int j = 0; j < ctr_pkg::QUO_BITS; j++) begin
      div_r[j+1] <= div_r[j];
      rem_r[j+1] <= rem_nxt[j];
      q_r[j+1]   <= q_nxt[j];
    end
  end

  assign quo = q_r[ctr_pkg::QUO_BITS];

endmodule

/* dv/tb_color_temperature_to_rgb_top.sv */
`timescale 1ns / 1ps
module tb_color_temperature_to_rgb_top;

  typedef struct packed {
    logic [ctr_pkg::LEVEL_BITS-1:0] red;
    logic [ctr_pkg::LEVEL_BITS-1:0] green;
    logic [ctr_pkg::LEVEL_BITS-1:0] blue;
  } rgb_t;

  localparam int DRAIN_CYCLES = ctr_pkg::OUT_LAT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_kelvin = '0;
  logic out_valid;
  logic [ctr_pkg::LEVEL_BITS-1:0] out_red_level;
  logic [ctr_pkg::LEVEL_BITS-1:0] out_green_level;
  logic [ctr_pkg::LEVEL_BITS-1:0] out_blue_level;

  logic [15:0] kelvin_queue[$];
  rgb_t        rgb_expected[$];
  int          fail_count = 0;
  int          issued_count = 0;
  int          gap_left = 0;
  int          burst_left = 1;
  bit          pausing = 1'b0;
  bit          paused_once = 1'b0;

  color_temperature_to_rgb_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_kelvin(in_kelvin),
    .out_valid(out_valid), .out_red_level(out_red_level),
    .out_green_level(out_green_level), .out_blue_level(out_blue_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Log2 in Q28 by normalizing to Q31 and repeated squaring.
  function automatic logic [63:0] log2_q28(input logic [31:0] x);
    logic [63:0] m;
    logic [63:0] r;
    int n;
    n = 0;
    if (x == 0) return 64'd0;
    for (int i = 1; i < 32; i++) begin
      if (x[i]) n = i;
    end
    m = 64'(x) << (31 - n);
    r = 64'(n) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Natural log of x/100 in Q28, zero when x/100 is at most one.
  function automatic logic [63:0] ln_hundredths(input logic [31:0] x);
    logic [63:0] lx;
    logic [63:0] lh;
    lx = log2_q28(x);
    lh = log2_q28(32'd100);
    if (lx <= lh) return 64'd0;
    return ((lx - lh) * 64'd2977044472) >> 32;
  endfunction

  // coef * (x/100)^-p through a truncated exponential series; Q28 result.
  function automatic logic [63:0] power_curve(input logic [63:0] coef,
                                              input logic [63:0] p,
                                              input logic [31:0] x);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y = (p * ln_hundredths(x)) >> 30;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      sum = sum + term;
    end
    return ((coef << 30) / sum) << 8;
  endfunction

  // mul * ln(x/100) - sub, floored at zero; Q28 result.
  function automatic logic [63:0] log_curve(input logic [63:0] mul,
                                            input logic [63:0] sub,
                                            input logic [31:0] x);
    logic [63:0] prod;
    logic [63:0] off;
    prod = (mul * ln_hundredths(x)) >> 20;
    off = sub << 8;
    return (prod > off) ? prod - off : 64'd0;
  endfunction

  // Channel value in Q28 (nominally 0..255) to a level, rounding half up.
  function automatic logic [ctr_pkg::LEVEL_BITS-1:0] level_of(input logic [63:0] v);
    logic [63:0] cap;
    logic [63:0] full;
    cap = 64'd255 << 28;
    full = (64'd1 << ctr_pkg::LEVEL_BITS) - 1;
    if (v > cap) v = cap;
    return ctr_pkg::LEVEL_BITS'(((v * full + (cap >> 1)) / cap) & full);
  endfunction

  function automatic rgb_t predict_rgb(input logic [15:0] kelvin);
    logic [31:0] k;
    logic [63:0] r;
    logic [63:0] g;
    logic [63:0] b;
    rgb_t res;
    k = 32'(kelvin);
    if (k < 1000) k = 1000;
    if (k > 40000) k = 40000;
    if (k <= 6600) begin
      r = 64'd255 << 28;
      g = log_curve(64'(ctr_pkg::G_LOW_MUL), 64'(ctr_pkg::G_LOW_SUB), k);
      b = (k <= 1900) ? 64'd0
          : log_curve(64'(ctr_pkg::B_LOW_MUL), 64'(ctr_pkg::B_LOW_SUB), k - 1000);
    end else begin
      r = power_curve(64'(ctr_pkg::R_HIGH_MUL), 64'(ctr_pkg::R_HIGH_EXP), k - 6000);
      g = power_curve(64'(ctr_pkg::G_HIGH_MUL), 64'(ctr_pkg::G_HIGH_EXP), k - 6000);
      b = 64'd255 << 28;
    end
    res.red = level_of(r);
    res.green = level_of(g);
    res.blue = level_of(b);
    return res;
  endfunction

  // Driver: bursts of words with random gaps, one pause until the pipe drains.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_kelvin <= '0;
    end else begin
      if (start && !busy) rgb_expected.push_back(predict_rgb(in_kelvin));
      if (start && busy) begin
        // Hold the word until it is taken.
      end else if (pausing) begin
        start <= 1'b0;
        if (rgb_expected.size() == 0 && !start) pausing <= 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (kelvin_queue.size() > 0) begin
        start <= 1'b1;
        in_kelvin <= kelvin_queue.pop_front();
        issued_count <= issued_count + 1;
        if (issued_count == 200 && !paused_once) begin
          pausing <= 1'b1;
          paused_once <= 1'b1;
        end
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed word is checked against the oldest prediction.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected result word: red %0d green %0d blue %0d",
               out_red_level, out_green_level, out_blue_level);
        fail_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (out_red_level !== want.red) begin
          $error("red_level expected %0d actual %0d", want.red, out_red_level);
          fail_count++;
        end
        if (out_green_level !== want.green) begin
          $error("green_level expected %0d actual %0d", want.green, out_green_level);
          fail_count++;
        end
        if (out_blue_level !== want.blue) begin
          $error("blue_level expected %0d actual %0d", want.blue, out_blue_level);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: range edges and breakpoints first, then random temperatures.
  initial begin
    logic [15:0] directed[$];
    directed = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1899, 16'd1900,
                 16'd1901, 16'd1999, 16'd2000, 16'd2100, 16'd6599, 16'd6600,
                 16'd6601, 16'd6699, 16'd6700, 16'd12000, 16'd39999, 16'd40000,
                 16'd40001, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFF};
    foreach (directed[i]) kelvin_queue.push_back(directed[i]);
    for (int i = 0; i < 400; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    kelvin_queue.push_back(16'($urandom_range(0, 65535)));
        2, 3, 4: kelvin_queue.push_back(16'($urandom_range(1000, 6600)));
        default: kelvin_queue.push_back(16'($urandom_range(6601, 40000)));
      endcase
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (kelvin_queue.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && rgb_expected.size() == 0) begin
      $display("tb_color_temperature_to_rgb_top passed");
    end else begin
      $display("tb_color_temperature_to_rgb_top failed");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #1000000;
    $display("tb_color_temperature_to_rgb_top failed");
    $finish;
  end

endmodule
